// File: rtl/core/cmfts_pkg.sv
package cmfts_pkg;

   localparam int MAX_FACE_SIZE = 4096;

   localparam int DIR_W    = 16;
   localparam int SIZE_W   = 13;
   localparam int COORD_W  = 12;
   localparam int OFFSET_W = 24;
   localparam int FACE_W   = 3;
   localparam int MAG_W    = DIR_W;           // magnitude of a component, up to 32768
   localparam int COMP_W   = DIR_W + 1;       // signed face coordinate, may be +32768
   localparam int SUM_W    = DIR_W + 1;       // m + c, 0 .. 65536
   localparam int DEN_W    = MAG_W + 1;       // 2 * m
   localparam int NUM_W    = SIZE_W + SUM_W;  // size * (m + c)
   localparam int QUO_W    = SIZE_W;          // quotient never exceeds size
   localparam int PROD_W   = COORD_W + SIZE_W;
   localparam int CSR_IDX_W = 2;

   localparam int DIV_STEPS = QUO_W;
   localparam int NSTAGE    = 2 + DIV_STEPS + 3;

   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_FACE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FACE_HEIGHT = 2'd1;

   localparam logic [SIZE_W-1:0] RESET_FACE_SIZE = 13'd64;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] lo;
      logic [QUO_W-1:0] quo;
   } cmfts_lane_type;

   typedef struct packed {
      logic [FACE_W-1:0]   face;
      logic                zero;
      logic [DEN_W-1:0]    den;
      cmfts_lane_type [1:0] lanes;   // lane 0 is the column, lane 1 the row
   } cmfts_div_type;

   typedef struct packed {
      logic [FACE_W-1:0]   face;
      logic [COORD_W-1:0]  texel_col;
      logic [COORD_W-1:0]  texel_row;
      logic [OFFSET_W-1:0] texel_offset;
      logic                zero_dir;
   } cmfts_rsp_type;

   // A size register of zero counts as one; large values saturate.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size_reg);
      logic [SIZE_W-1:0] result;
      if (size_reg == '0) begin
         result = SIZE_W'(1);
      end else if (size_reg > SIZE_W'(MAX_FACE_SIZE)) begin
         result = SIZE_W'(MAX_FACE_SIZE);
      end else begin
         result = size_reg;
      end
      return result;
   endfunction

endpackage

// File: rtl/core/cmfts_if.sv
interface cmfts_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [cmfts_pkg::DIR_W-1:0]  dir_x;
   logic signed [cmfts_pkg::DIR_W-1:0]  dir_y;
   logic signed [cmfts_pkg::DIR_W-1:0]  dir_z;
   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmfts_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [cmfts_pkg::FACE_W-1:0]        face;
   logic [cmfts_pkg::COORD_W-1:0]       texel_col;
   logic [cmfts_pkg::COORD_W-1:0]       texel_row;
   logic [cmfts_pkg::OFFSET_W-1:0]      texel_offset;
   logic                                zero_dir;
   modport source (output valid, output face, output texel_col, output texel_row,
                   output texel_offset, output zero_dir, input ready);
   modport sink   (input valid, input face, input texel_col, input texel_row,
                   input texel_offset, input zero_dir, output ready);
endinterface

interface cmfts_csr_if;
   logic                                valid;
   logic                                ready;
   logic [cmfts_pkg::CSR_IDX_W-1:0]     index;
   logic [cmfts_pkg::SIZE_W-1:0]        data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/cmfts_classify.sv
module cmfts_classify (
   input  logic                                clock,
   input  logic [1:0]                          en,
   input  logic signed [cmfts_pkg::DIR_W-1:0]  dir_x,
   input  logic signed [cmfts_pkg::DIR_W-1:0]  dir_y,
   input  logic signed [cmfts_pkg::DIR_W-1:0]  dir_z,
   input  logic [cmfts_pkg::SIZE_W-1:0]        width_eff,
   input  logic [cmfts_pkg::SIZE_W-1:0]        height_eff,
   output cmfts_pkg::cmfts_div_type            div_ff
);

   logic [cmfts_pkg::MAG_W-1:0]          ax, ay, az, mag;
   logic signed [cmfts_pkg::COMP_W-1:0]  xe, ye, ze, cu, cv;
   logic signed [cmfts_pkg::COMP_W:0]    su_full, sv_full;
   logic [cmfts_pkg::FACE_W-1:0]         face;
   logic                                 zero;

   logic [cmfts_pkg::FACE_W-1:0]  face_ff;
   logic                          zero_ff;
   logic [cmfts_pkg::MAG_W-1:0]   mag_ff;
   logic [cmfts_pkg::SUM_W-1:0]   sum_u_ff, sum_v_ff;

   logic [cmfts_pkg::NUM_W-1:0]   num_u, num_v;
   cmfts_pkg::cmfts_div_type      div_in;

   always_comb begin
      ax = dir_x[cmfts_pkg::DIR_W-1] ? cmfts_pkg::MAG_W'(-dir_x) : cmfts_pkg::MAG_W'(dir_x);
      ay = dir_y[cmfts_pkg::DIR_W-1] ? cmfts_pkg::MAG_W'(-dir_y) : cmfts_pkg::MAG_W'(dir_y);
      az = dir_z[cmfts_pkg::DIR_W-1] ? cmfts_pkg::MAG_W'(-dir_z) : cmfts_pkg::MAG_W'(dir_z);
      xe = {dir_x[cmfts_pkg::DIR_W-1], dir_x};
      ye = {dir_y[cmfts_pkg::DIR_W-1], dir_y};
      ze = {dir_z[cmfts_pkg::DIR_W-1], dir_z};

      // Ties go to z first, then to y.
      if ((az >= ax) && (az >= ay)) begin
         face = dir_z[cmfts_pkg::DIR_W-1] ? cmfts_pkg::FACE_NEG_Z : cmfts_pkg::FACE_POS_Z;
         mag  = az;
         cu   = dir_z[cmfts_pkg::DIR_W-1] ? -xe : xe;
         cv   = ye;
      end else if (ay >= ax) begin
         face = dir_y[cmfts_pkg::DIR_W-1] ? cmfts_pkg::FACE_NEG_Y : cmfts_pkg::FACE_POS_Y;
         mag  = ay;
         cu   = xe;
         cv   = dir_y[cmfts_pkg::DIR_W-1] ? -ze : ze;
      end else begin
         face = dir_x[cmfts_pkg::DIR_W-1] ? cmfts_pkg::FACE_NEG_X : cmfts_pkg::FACE_POS_X;
         mag  = ax;
         cu   = dir_x[cmfts_pkg::DIR_W-1] ? ze : -ze;
         cv   = -ye;
      end

      zero = (mag == '0);
      if (zero) begin
         face = cmfts_pkg::FACE_POS_Z;
      end

      su_full = $signed({2'b00, mag}) + $signed({cu[cmfts_pkg::COMP_W-1], cu});
      sv_full = $signed({2'b00, mag}) + $signed({cv[cmfts_pkg::COMP_W-1], cv});
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         face_ff  <= face;
         zero_ff  <= zero;
         mag_ff   <= mag;
         sum_u_ff <= su_full[cmfts_pkg::SUM_W-1:0];
         sum_v_ff <= sv_full[cmfts_pkg::SUM_W-1:0];
      end
   end

   // The quotient fits in QUO_W bits, so the upper numerator bits start out
   // below the divisor and seed the remainder directly.
   always_comb begin
      num_u = {{cmfts_pkg::SUM_W{1'b0}}, width_eff} *
              {{cmfts_pkg::SIZE_W{1'b0}}, sum_u_ff};
      num_v = {{cmfts_pkg::SUM_W{1'b0}}, height_eff} *
              {{cmfts_pkg::SIZE_W{1'b0}}, sum_v_ff};
      div_in.face           = face_ff;
      div_in.zero           = zero_ff;
      div_in.den            = {mag_ff, 1'b0};
      div_in.lanes[0].rem   = num_u[cmfts_pkg::NUM_W-1:cmfts_pkg::QUO_W];
      div_in.lanes[0].lo    = num_u[cmfts_pkg::QUO_W-1:0];
      div_in.lanes[0].quo   = '0;
      div_in.lanes[1].rem   = num_v[cmfts_pkg::NUM_W-1:cmfts_pkg::QUO_W];
      div_in.lanes[1].lo    = num_v[cmfts_pkg::QUO_W-1:0];
      div_in.lanes[1].quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         div_ff <= div_in;
      end
   end

endmodule

// File: rtl/core/cmfts_div_step.sv
module cmfts_div_step (
   input  logic                      clock,
   input  logic                      en,
   input  cmfts_pkg::cmfts_div_type  stage_d,
   output cmfts_pkg::cmfts_div_type  step_ff
);

   cmfts_pkg::cmfts_div_type        step_in;
   logic [cmfts_pkg::DEN_W:0]       trial [2];
   logic [cmfts_pkg::DEN_W:0]       den_ext;

   // One restoring step per lane: shift in the next numerator bit and
   // subtract the divisor when it fits.
   always_comb begin
      step_in = stage_d;
      den_ext = {1'b0, stage_d.den};
      for (int j = 0; j < 2; j++) begin
         trial[j] = {stage_d.lanes[j].rem, stage_d.lanes[j].lo[cmfts_pkg::QUO_W-1]};
         step_in.lanes[j].lo = {stage_d.lanes[j].lo[cmfts_pkg::QUO_W-2:0], 1'b0};
         if (trial[j] >= den_ext) begin
            step_in.lanes[j].rem = cmfts_pkg::DEN_W'(trial[j] - den_ext);
            step_in.lanes[j].quo = {stage_d.lanes[j].quo[cmfts_pkg::QUO_W-2:0], 1'b1};
         end else begin
            step_in.lanes[j].rem = trial[j][cmfts_pkg::DEN_W-1:0];
            step_in.lanes[j].quo = {stage_d.lanes[j].quo[cmfts_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

endmodule

// File: rtl/core/cmfts_finish.sv
module cmfts_finish (
   input  logic                          clock,
   input  logic [2:0]                    en,
   input  cmfts_pkg::cmfts_div_type      div_d,
   input  logic [cmfts_pkg::SIZE_W-1:0]  width_eff,
   input  logic [cmfts_pkg::SIZE_W-1:0]  height_eff,
   output cmfts_pkg::cmfts_rsp_type      rsp_ff
);

   logic [cmfts_pkg::SIZE_W-1:0]    w_max, h_max, col_full, row_full;

   logic [cmfts_pkg::FACE_W-1:0]    face_ff, face2_ff;
   logic                            zero_ff, zero2_ff;
   logic [cmfts_pkg::COORD_W-1:0]   col_ff, row_ff, col2_ff, row2_ff;
   logic [cmfts_pkg::PROD_W-1:0]    prod_ff;
   logic [cmfts_pkg::PROD_W:0]      off_sum;
   cmfts_pkg::cmfts_rsp_type        rsp_in;

   always_comb begin
      w_max = width_eff - cmfts_pkg::SIZE_W'(1);
      h_max = height_eff - cmfts_pkg::SIZE_W'(1);
      // A zero direction lands on the centre texel; half the size never
      // exceeds size minus one.
      if (div_d.zero) begin
         col_full = width_eff >> 1;
         row_full = height_eff >> 1;
      end else begin
         col_full = (div_d.lanes[0].quo > w_max) ? w_max : div_d.lanes[0].quo;
         row_full = (div_d.lanes[1].quo > h_max) ? h_max : div_d.lanes[1].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         face_ff <= div_d.face;
         zero_ff <= div_d.zero;
         col_ff  <= col_full[cmfts_pkg::COORD_W-1:0];
         row_ff  <= row_full[cmfts_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         face2_ff <= face_ff;
         zero2_ff <= zero_ff;
         col2_ff  <= col_ff;
         row2_ff  <= row_ff;
         prod_ff  <= {{cmfts_pkg::SIZE_W{1'b0}}, row_ff} *
                     {{cmfts_pkg::COORD_W{1'b0}}, width_eff};
      end
   end

   always_comb begin
      off_sum             = {{(cmfts_pkg::PROD_W - cmfts_pkg::COORD_W + 1){1'b0}}, col2_ff} +
                            {1'b0, prod_ff};
      rsp_in.face         = face2_ff;
      rsp_in.texel_col    = col2_ff;
      rsp_in.texel_row    = row2_ff;
      rsp_in.texel_offset = off_sum[cmfts_pkg::OFFSET_W-1:0];
      rsp_in.zero_dir     = zero2_ff;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/core/cube_map_face_texel_select.sv
// A request passes through 18 register stages (two for face selection and
// scaling, 13 for the bit-per-stage divider, three for clamping and the offset
// multiply-add).
// Throughput: one request per cycle; every stage holds under back-pressure.
// Reset: synchronous, active high; clears all stage valid bits and sets both
// face sizes to 64.
module cube_map_face_texel_select (
   input  logic            clock,
   input  logic            reset,
   cmfts_req_if.sink       req_chan,
   cmfts_rsp_if.source     rsp_chan,
   cmfts_csr_if.sink       csr_chan
);

   localparam int NS = cmfts_pkg::NSTAGE;
   localparam int DS = cmfts_pkg::DIV_STEPS;

   logic [cmfts_pkg::SIZE_W-1:0]  width_ff, height_ff, width_in, height_in;
   logic [cmfts_pkg::SIZE_W-1:0]  width_eff, height_eff;

   logic [NS-1:0]  valid_ff, valid_in, vsrc;
   logic [NS:0]    rdy;

   cmfts_pkg::cmfts_div_type      div_chain [DS+1];
   cmfts_pkg::cmfts_rsp_type      rsp_data;

   // Configuration registers.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            cmfts_pkg::REG_FACE_WIDTH:  width_in  = csr_chan.data;
            cmfts_pkg::REG_FACE_HEIGHT: height_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cmfts_pkg::RESET_FACE_SIZE;
         height_ff <= cmfts_pkg::RESET_FACE_SIZE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_chan.ready = 1'b1;
   assign width_eff      = cmfts_pkg::eff_size(width_ff);
   assign height_eff     = cmfts_pkg::eff_size(height_ff);

   // A stage loads when it is empty or its successor moves on.
   always_comb begin
      rdy[NS] = rsp_chan.ready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
      vsrc = {valid_ff[NS-2:0], req_chan.valid};
      for (int i = 0; i < NS; i++) begin
         valid_in[i] = rdy[i] ? vsrc[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = rdy[0];

   cmfts_classify u_classify (
      .clock      (clock),
      .en         (rdy[1:0]),
      .dir_x      (req_chan.dir_x),
      .dir_y      (req_chan.dir_y),
      .dir_z      (req_chan.dir_z),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .div_ff     (div_chain[0])
   );

   for (genvar k = 0; k < DS; k++) begin : g_div
      cmfts_div_step u_step (
         .clock   (clock),
         .en      (rdy[2+k]),
         .stage_d (div_chain[k]),
         .step_ff (div_chain[k+1])
      );
   end

   cmfts_finish u_finish (
      .clock      (clock),
      .en         (rdy[NS-1:NS-3]),
      .div_d      (div_chain[DS]),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .rsp_ff     (rsp_data)
   );

   assign rsp_chan.valid        = valid_ff[NS-1];
   assign rsp_chan.face         = rsp_data.face;
   assign rsp_chan.texel_col    = rsp_data.texel_col;
   assign rsp_chan.texel_row    = rsp_data.texel_row;
   assign rsp_chan.texel_offset = rsp_data.texel_offset;
   assign rsp_chan.zero_dir     = rsp_data.zero_dir;

   // Requests are refused only when every stage holds an item.
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (&valid_ff))
      else $error("request refused while a pipeline stage is empty");

   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.face <= cmfts_pkg::FACE_NEG_Z))
      else $error("face index out of range");

   a_texel_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ({1'b0, rsp_chan.texel_col} < width_eff) &&
                         ({1'b0, rsp_chan.texel_row} < height_eff))
      else $error("texel coordinate beyond face size");

   a_zero_centre: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_dir |->
         (rsp_chan.face == cmfts_pkg::FACE_POS_Z) &&
         ({1'b0, rsp_chan.texel_col} == (width_eff >> 1)) &&
         ({1'b0, rsp_chan.texel_row} == (height_eff >> 1)))
      else $error("zero direction not mapped to the centre of +z");

endmodule

// File: verif/tb_cube_map_face_texel_select.sv
`timescale 1ns / 1ps

module tb_cube_map_face_texel_select;

   // Indexes past the two size registers; writes to them must change nothing.
   localparam logic [cmfts_pkg::CSR_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
   localparam logic [cmfts_pkg::CSR_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

   localparam int PIPE_DRAIN  = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SQUEEZE_AT  = 400;
   localparam int SQUEEZE_LEN = 120;

   typedef struct {
      logic signed [cmfts_pkg::DIR_W-1:0] x;
      logic signed [cmfts_pkg::DIR_W-1:0] y;
      logic signed [cmfts_pkg::DIR_W-1:0] z;
   } lookup_dir_type;

   logic clock;
   logic reset;

   cmfts_req_if req_chan ();
   cmfts_rsp_if rsp_chan ();
   cmfts_csr_if csr_chan ();

   cube_map_face_texel_select u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   logic [cmfts_pkg::SIZE_W-1:0] width_shadow;
   logic [cmfts_pkg::SIZE_W-1:0] height_shadow;

   lookup_dir_type           pending_dirs[$];
   cmfts_pkg::cmfts_rsp_type texel_expect_q[$];

   bit calm;
   int error_count;
   int send_gap;
   int hold_left;
   int results_seen;
   bit squeezed;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned usable_size(input logic [cmfts_pkg::SIZE_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > cmfts_pkg::MAX_FACE_SIZE) return cmfts_pkg::MAX_FACE_SIZE;
      return raw;
   endfunction

   // floor(size * (m + c) / (2m)), clamped to the last texel.
   function automatic int unsigned texel_from_coord(input int unsigned size, input int m,
                                                    input int c);
      longint unsigned t;
      t = (longint'(size) * longint'(m + c)) / longint'(2 * m);
      if (t > size - 1) t = size - 1;
      return int'(t);
   endfunction

   function automatic cmfts_pkg::cmfts_rsp_type predict_lookup(input lookup_dir_type d);
      int x, y, z, ax, ay, az, m, u, v;
      int unsigned w, h, col, row;
      logic [cmfts_pkg::FACE_W-1:0] face;
      cmfts_pkg::cmfts_rsp_type r;
      x = d.x;
      y = d.y;
      z = d.z;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      w = usable_size(width_shadow);
      h = usable_size(height_shadow);
      if (az >= ax && az >= ay) begin
         face = (z < 0) ? cmfts_pkg::FACE_NEG_Z : cmfts_pkg::FACE_POS_Z;
         m = az;
         u = (z < 0) ? -x : x;
         v = y;
      end else if (ay >= ax) begin
         face = (y < 0) ? cmfts_pkg::FACE_NEG_Y : cmfts_pkg::FACE_POS_Y;
         m = ay;
         u = x;
         v = (y < 0) ? -z : z;
      end else begin
         face = (x < 0) ? cmfts_pkg::FACE_NEG_X : cmfts_pkg::FACE_POS_X;
         m = ax;
         u = (x < 0) ? z : -z;
         v = -y;
      end
      if (m == 0) begin
         face = cmfts_pkg::FACE_POS_Z;
         col = w / 2;
         row = h / 2;
         if (col > w - 1) col = w - 1;
         if (row > h - 1) row = h - 1;
      end else begin
         col = texel_from_coord(w, m, u);
         row = texel_from_coord(h, m, v);
      end
      r.face = face;
      r.texel_col = cmfts_pkg::COORD_W'(col);
      r.texel_row = cmfts_pkg::COORD_W'(row);
      r.texel_offset = cmfts_pkg::OFFSET_W'(longint'(col) + longint'(row) * longint'(w));
      r.zero_dir = (m == 0);
      return r;
   endfunction

   function automatic logic signed [cmfts_pkg::DIR_W-1:0] signed_mag(input int mag);
      int val;
      val = ($urandom_range(0, 1) == 1) ? -mag : mag;
      return cmfts_pkg::DIR_W'(val);
   endfunction

   function automatic lookup_dir_type make_random_dir();
      lookup_dir_type d;
      int a;
      int pick;
      int k;
      pick = $urandom_range(0, 9);
      d.x = cmfts_pkg::DIR_W'($urandom);
      d.y = cmfts_pkg::DIR_W'($urandom);
      d.z = cmfts_pkg::DIR_W'($urandom);
      case (pick)
         5: begin
            d.x = cmfts_pkg::DIR_W'(int'($urandom_range(0, 8)) - 4);
            d.y = cmfts_pkg::DIR_W'(int'($urandom_range(0, 8)) - 4);
            d.z = cmfts_pkg::DIR_W'(int'($urandom_range(0, 8)) - 4);
         end
         6: begin
            // Two or three components share the largest magnitude.
            a = $urandom_range(1, 32768);
            k = $urandom_range(0, 3);
            d.x = signed_mag(int'($urandom_range(0, a)));
            d.y = signed_mag(int'($urandom_range(0, a)));
            d.z = signed_mag(int'($urandom_range(0, a)));
            if (k != 2) d.x = signed_mag(a);
            if (k != 1) d.y = signed_mag(a);
            if (k != 0) d.z = signed_mag(a);
         end
         7: begin
            k = $urandom_range(0, 2);
            a = ($urandom_range(0, 1) == 1) ? -32768 : 32767;
            if (k == 0) d.x = cmfts_pkg::DIR_W'(a);
            else if (k == 1) d.y = cmfts_pkg::DIR_W'(a);
            else d.z = cmfts_pkg::DIR_W'(a);
         end
         8: begin
            k = $urandom_range(0, 3);
            if (k != 0) d.x = '0;
            if (k != 1) d.y = '0;
            if (k != 2) d.z = '0;
         end
         9: begin
            d.x = cmfts_pkg::DIR_W'($signed(8'($urandom)));
            d.y = cmfts_pkg::DIR_W'($signed(8'($urandom)));
            d.z = cmfts_pkg::DIR_W'($signed(8'($urandom)));
         end
         default: begin
         end
      endcase
      return d;
   endfunction

   task automatic push_dir(input int x, input int y, input int z);
      lookup_dir_type d;
      d.x = cmfts_pkg::DIR_W'(x);
      d.y = cmfts_pkg::DIR_W'(y);
      d.z = cmfts_pkg::DIR_W'(z);
      pending_dirs.insert(pending_dirs.size(), d);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         pending_dirs.insert(pending_dirs.size(), make_random_dir());
      end
   endtask

   task automatic report_error(input string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      error_count++;
   endtask

   task automatic write_size(input logic [cmfts_pkg::CSR_IDX_W-1:0] idx,
                             input logic [cmfts_pkg::SIZE_W-1:0] val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == cmfts_pkg::REG_FACE_WIDTH) width_shadow = val;
      else if (idx == cmfts_pkg::REG_FACE_HEIGHT) height_shadow = val;
   endtask

   task automatic finish_phase();
      while (pending_dirs.size() != 0 || req_chan.valid || texel_expect_q.size() != 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   always @(posedge clock) begin : req_driver
      lookup_dir_type sent;
      lookup_dir_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            sent.x = req_chan.dir_x;
            sent.y = req_chan.dir_y;
            sent.z = req_chan.dir_z;
            texel_expect_q.insert(texel_expect_q.size(), predict_lookup(sent));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_dirs.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap <= $urandom_range(0, 8);
               req_chan.valid <= 1'b0;
            end else begin
               nxt = pending_dirs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.dir_x <= nxt.x;
               req_chan.dir_y <= nxt.y;
               req_chan.dir_z <= nxt.z;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      cmfts_pkg::cmfts_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= 0;
         results_seen <= 0;
         squeezed <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen <= results_seen + 1;
            if (texel_expect_q.size() == 0) begin
               report_error("result transfer with nothing expected");
            end else begin
               want = texel_expect_q.pop_front();
               if (rsp_chan.face !== want.face)
                  report_error($sformatf("face expected %0d, got %0d",
                                         want.face, rsp_chan.face));
               if (rsp_chan.texel_col !== want.texel_col)
                  report_error($sformatf("texel_col expected %0d, got %0d",
                                         want.texel_col, rsp_chan.texel_col));
               if (rsp_chan.texel_row !== want.texel_row)
                  report_error($sformatf("texel_row expected %0d, got %0d",
                                         want.texel_row, rsp_chan.texel_row));
               if (rsp_chan.texel_offset !== want.texel_offset)
                  report_error($sformatf("texel_offset expected %0d, got %0d",
                                         want.texel_offset, rsp_chan.texel_offset));
               if (rsp_chan.zero_dir !== want.zero_dir)
                  report_error($sformatf("zero_dir expected %0d, got %0d",
                                         want.zero_dir, rsp_chan.zero_dir));
            end
         end
         // One long hold-off fills the pipeline so the request side backs up.
         if (!squeezed && results_seen == SQUEEZE_AT) begin
            squeezed <= 1'b1;
            hold_left <= SQUEEZE_LEN;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_left <= $urandom_range(0, 8);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [cmfts_pkg::SIZE_W-1:0] w;
      logic [cmfts_pkg::SIZE_W-1:0] h;
      reset = 1'b1;
      calm = 1'b0;
      error_count = 0;
      width_shadow = cmfts_pkg::RESET_FACE_SIZE;
      height_shadow = cmfts_pkg::RESET_FACE_SIZE;
      req_chan.valid = 1'b0;
      req_chan.dir_x = '0;
      req_chan.dir_y = '0;
      req_chan.dir_z = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = cmfts_pkg::REG_FACE_WIDTH;
      csr_chan.data  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed lookups at the reset face size.
      push_dir(0, 0, 0);
      push_dir(100, 0, 0);
      push_dir(-100, 0, 0);
      push_dir(0, 100, 0);
      push_dir(0, -100, 0);
      push_dir(0, 0, 100);
      push_dir(0, 0, -100);
      push_dir(5, 5, 5);
      push_dir(7, 7, 0);
      push_dir(7, -7, 3);
      push_dir(-9, 3, 9);
      push_dir(0, -4, 4);
      push_dir(100, 0, 100);
      push_dir(-100, -100, -100);
      push_dir(-32768, -32768, -32768);
      push_dir(32767, 32767, 32767);
      push_dir(-32768, 32767, 0);
      push_dir(32767, -32768, -32768);
      push_dir(-32768, 0, 32767);
      push_dir(1, 0, 0);
      push_dir(-1, 0, 0);
      push_dir(0, 0, -1);
      queue_random(130);
      finish_phase();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin w = 13'd1;    h = 13'd1;    end
            1: begin w = 13'd4096; h = 13'd4096; end
            2: begin w = 13'd0;    h = 13'd8191; end
            3: begin w = 13'd8191; h = 13'd0;    end
            4: begin w = 13'd4097; h = 13'd2;    end
            5: begin w = 13'd3;    h = 13'd4095; end
            6: begin
               w = cmfts_pkg::SIZE_W'($urandom_range(1, 4096));
               h = cmfts_pkg::SIZE_W'($urandom_range(1, 4096));
            end
            default: begin
               w = cmfts_pkg::SIZE_W'($urandom_range(1, 200));
               h = cmfts_pkg::SIZE_W'($urandom_range(1, 200));
               calm = 1'b1;
            end
         endcase
         write_size(cmfts_pkg::REG_FACE_WIDTH, w);
         write_size(cmfts_pkg::REG_FACE_HEIGHT, h);
         if (p == 2 || p == 6) begin
            write_size(REG_UNUSED_2, cmfts_pkg::SIZE_W'($urandom));
            write_size(REG_UNUSED_3, cmfts_pkg::SIZE_W'($urandom));
         end
         queue_random(150);
         finish_phase();
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/cmfts_pkg.sv
rtl/core/cmfts_if.sv
rtl/core/cmfts_classify.sv
rtl/core/cmfts_div_step.sv
rtl/core/cmfts_finish.sv
rtl/core/cube_map_face_texel_select.sv
verif/tb_cube_map_face_texel_select.sv
